### hw/rtl/lts_pkg.sv
`default_nettype none

package lts_pkg;

  localparam int PID_W  = 15;
  localparam int RND_W  = 31;
  localparam int QNT_W  = 16;
  localparam int TKT_W  = 8;
  localparam int CFG_W  = 16;
  localparam int STEP_W = 5;

  localparam logic [QNT_W-1:0] QUANTUM_RST = 16'd5;
  localparam logic [TKT_W-1:0] TICKETS_RST = 8'd10;

  typedef enum logic [2:0] {
    OP_LOAD    = 3'd0,
    OP_UNBLOCK = 3'd1,
    OP_TICK    = 3'd2,
    OP_EXIT    = 3'd3,
    OP_BLOCK   = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_e;

  typedef enum logic {
    REG_QUANTUM = 1'b0,
    REG_TICKETS = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic [2:0]       operation;
    logic [PID_W-1:0] pid;
    logic [PID_W-1:0] running_pid;
    logic             current_is_idle;
    logic [RND_W-1:0] random_value;
  } cmd_t;

  typedef struct packed {
    logic [PID_W-1:0] next_pid;
    logic             next_is_idle;
    logic [1:0]       status;
  } result_t;

  typedef struct packed {
    logic push;      // shift toward the back, new pid enters at the front
    logic compare;   // mark entries that match the running task
    logic scan;      // ripple the match mark one cell toward the back
    logic pull;      // close the gap behind the first match
    logic rd_load;   // copy entries into the readout line
    logic rd_shift;  // advance the readout line toward the front
  } cell_ctrl_t;

endpackage

`default_nettype wire

### hw/rtl/lts_cell.sv
`default_nettype none

module lts_cell import lts_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire cell_ctrl_t       ctrl_i,
  input  wire logic             in_range_i,
  input  wire logic [PID_W-1:0] cur_pid_i,
  input  wire logic [PID_W-1:0] left_pid_i,
  input  wire logic [PID_W-1:0] right_pid_i,
  input  wire logic             left_mark_i,
  input  wire logic [PID_W-1:0] right_rd_i,
  output logic      [PID_W-1:0] pid_o,
  output logic      [PID_W-1:0] rd_o,
  output logic                  match_o,
  output logic                  mark_o
);

  logic [PID_W-1:0] pid_q;
  logic [PID_W-1:0] rd_q;
  logic             match_q;
  logic             seen_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.push) begin
      pid_q <= left_pid_i;
    end else if (ctrl_i.pull && (seen_q || match_q)) begin
      pid_q <= right_pid_i;
    end
    if (ctrl_i.rd_load) begin
      rd_q <= pid_q;
    end else if (ctrl_i.rd_shift) begin
      rd_q <= right_rd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= 1'b0;
      seen_q  <= 1'b0;
    end else if (ctrl_i.compare) begin
      match_q <= in_range_i && (pid_q == cur_pid_i);
      seen_q  <= 1'b0;
    end else if (ctrl_i.scan) begin
      seen_q <= left_mark_i;
    end
  end

  assign pid_o   = pid_q;
  assign rd_o    = rd_q;
  assign match_o = match_q;
  assign mark_o  = seen_q || match_q;

endmodule

`default_nettype wire

### hw/rtl/lts_mod.sv
`default_nettype none

// Restoring remainder, one dividend bit per cycle.
module lts_mod import lts_pkg::*; #(
  parameter int DIV_W = 13
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [RND_W-1:0] dividend_i,
  input  wire logic [DIV_W-1:0] divisor_i,
  output logic                  done_o,
  output logic      [DIV_W-1:0] rem_o
);

  logic [DIV_W-1:0]  rem_q, rem_d;
  logic [RND_W-1:0]  dvd_q;
  logic [DIV_W-1:0]  div_q;
  logic [STEP_W-1:0] cnt_q;
  logic              run_q;
  logic              done_q;
  logic [DIV_W:0]    trial;

  assign trial = {rem_q, dvd_q[RND_W-1]};

  always_comb begin
    if (trial >= {1'b0, div_q}) begin
      rem_d = DIV_W'(trial - {1'b0, div_q});
    end else begin
      rem_d = trial[DIV_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      dvd_q <= dividend_i;
      div_q <= divisor_i;
    end else if (run_q) begin
      rem_q <= rem_d;
      dvd_q <= {dvd_q[RND_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= STEP_W'(RND_W - 1);
      end else if (run_q) begin
        cnt_q <= cnt_q - STEP_W'(1);
        if (cnt_q == '0) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

`default_nettype wire

### hw/rtl/lottery_task_scheduler_unit.sv
// Channel  | Ports                              | Transfer
// ---------+------------------------------------+------------------------------
// command  | start, cmd_i, busy                 | edge with start high, busy low
// result   | done_o, result_o                   | edge ending the done_o cycle
// config   | cfg_we_i, cfg_idx_i, cfg_data_i    | edge with cfg_we_i high
//
// Load, unblock, a tick without a draw and unknown operations answer in the
// next cycle. A draw goes through setup, 31 bit-serial remainder steps and the
// handoff to the walk, then shifts the readout line once per table entry
// walked past (up to MAX_TASKS - 1).
// When the running task is not idle, exit and block first ripple the match
// mark through the cells (MAX_TASKS - 1 scan steps and one pull) before the draw.
// Reset empties the table at once (count cleared).
// Busy is high while an item is in work; results cannot be stalled.
`default_nettype none

module lottery_task_scheduler_unit import lts_pkg::*; #(
  parameter int MAX_TASKS = 16
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start,
  input  wire cmd_t             cmd_i,
  output logic                  busy,
  output logic                  done_o,
  output result_t               result_o,
  input  wire logic             cfg_we_i,
  input  wire logic             cfg_idx_i,
  input  wire logic [CFG_W-1:0] cfg_data_i
);

  localparam int CW = $clog2(MAX_TASKS + 1);
  localparam int SW = $clog2(MAX_TASKS);
  localparam int TW = CW + TKT_W;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_SCAN  = 6'b000010,
    S_PULL  = 6'b000100,
    S_SETUP = 6'b001000,
    S_DIV   = 6'b010000,
    S_WALK  = 6'b100000
  } state_e;

  state_e           state_q, state_d;
  logic [QNT_W-1:0] quantum_q;
  logic [TKT_W-1:0] tickets_q;
  logic [TKT_W-1:0] tpt;
  logic [CW-1:0]    count_q, count_d, count_left;
  logic [QNT_W-1:0] tick_q, tick_d, tick_inc;
  logic [SW-1:0]    scan_q, scan_d;
  logic [TW-1:0]    ticket_q, ticket_d;
  logic [CW-1:0]    walk_q, walk_d;
  logic [RND_W-1:0] rnd_q, rnd_d;
  logic [1:0]       st_q, st_d, st_now;
  result_t          res_q, res_d, res_cur;
  logic             done_q, done_d;
  cell_ctrl_t       ctrl;
  logic             found;
  logic             mod_done;
  logic [TW-1:0]    mod_rem;

  logic [PID_W-1:0]     pid_w [MAX_TASKS];
  logic [PID_W-1:0]     rd_w  [MAX_TASKS];
  logic [MAX_TASKS-1:0] match_w;
  logic [MAX_TASKS-1:0] mark_w;

  assign tpt      = (tickets_q == '0) ? TKT_W'(1) : tickets_q;
  assign tick_inc = tick_q + QNT_W'(1);
  assign found    = |match_w;

  for (genvar i = 0; i < MAX_TASKS; i++) begin : g_cell
    logic [PID_W-1:0] left_pid, right_pid, right_rd;
    logic             left_mark;
    if (i == 0) begin : g_front
      assign left_pid  = cmd_i.pid;
      assign left_mark = 1'b0;
    end else begin : g_mid
      assign left_pid  = pid_w[i-1];
      assign left_mark = mark_w[i-1];
    end
    if (i == MAX_TASKS - 1) begin : g_back
      assign right_pid = pid_w[i];
      assign right_rd  = rd_w[i];
    end else begin : g_inner
      assign right_pid = pid_w[i+1];
      assign right_rd  = rd_w[i+1];
    end
    lts_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl),
      .in_range_i (CW'(i) < count_q),
      .cur_pid_i  (cmd_i.running_pid),
      .left_pid_i (left_pid),
      .right_pid_i(right_pid),
      .left_mark_i(left_mark),
      .right_rd_i (right_rd),
      .pid_o      (pid_w[i]),
      .rd_o       (rd_w[i]),
      .match_o    (match_w[i]),
      .mark_o     (mark_w[i])
    );
  end

  lts_mod #(.DIV_W(TW)) u_mod (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (state_q == S_SETUP),
    .dividend_i(rnd_q),
    .divisor_i (TW'(count_q) * TW'(tpt)),
    .done_o    (mod_done),
    .rem_o     (mod_rem)
  );

  always_comb begin
    res_cur.next_pid     = cmd_i.current_is_idle ? '0 : cmd_i.running_pid;
    res_cur.next_is_idle = cmd_i.current_is_idle;
    res_cur.status       = ST_OK;
  end

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    tick_d     = tick_q;
    scan_d     = scan_q;
    ticket_d   = ticket_q;
    walk_d     = walk_q;
    rnd_d      = rnd_q;
    st_d       = st_q;
    res_d      = res_q;
    done_d     = 1'b0;
    ctrl       = '0;
    st_now     = ST_NOT_FOUND;
    count_left = count_q;
    unique case (state_q)
      S_IDLE: begin
        if (start && !busy) begin
          // hold the draw value, the command may change after the transfer
          rnd_d = cmd_i.random_value;
          case (cmd_i.operation) inside
            OP_LOAD, OP_UNBLOCK: begin
              res_d  = res_cur;
              done_d = 1'b1;
              if (count_q == CW'(MAX_TASKS)) begin
                res_d.status = ST_FULL;
              end else begin
                ctrl.push = 1'b1;
                count_d   = count_q + CW'(1);
              end
            end
            OP_TICK: begin
              st_d = ST_OK;
              if (cmd_i.current_is_idle && count_q != '0) begin
                state_d = S_SETUP;
              end else if (tick_inc == quantum_q) begin
                tick_d = '0;
                if (count_q != '0) begin
                  state_d = S_SETUP;
                end else begin
                  res_d  = '{next_pid: '0, next_is_idle: 1'b1, status: ST_OK};
                  done_d = 1'b1;
                end
              end else begin
                tick_d = tick_inc;
                res_d  = res_cur;
                done_d = 1'b1;
              end
            end
            OP_EXIT, OP_BLOCK: begin
              tick_d = '0;
              if (!cmd_i.current_is_idle) begin
                ctrl.compare = 1'b1;
                scan_d       = SW'(MAX_TASKS - 1);
                state_d      = S_SCAN;
              end else begin
                st_d = ST_NOT_FOUND;
                if (count_q != '0) begin
                  state_d = S_SETUP;
                end else begin
                  res_d  = '{next_pid: '0, next_is_idle: 1'b1, status: ST_NOT_FOUND};
                  done_d = 1'b1;
                end
              end
            end
            default: begin
              res_d  = res_cur;
              done_d = 1'b1;
            end
          endcase
        end
      end
      S_SCAN: begin
        ctrl.scan = 1'b1;
        scan_d    = scan_q - SW'(1);
        if (scan_q == SW'(1)) begin
          state_d = S_PULL;
        end
      end
      S_PULL: begin
        if (found) begin
          ctrl.pull  = 1'b1;
          count_left = count_q - CW'(1);
          st_now     = ST_OK;
        end
        count_d = count_left;
        st_d    = st_now;
        if (count_left != '0) begin
          state_d = S_SETUP;
        end else begin
          res_d   = '{next_pid: '0, next_is_idle: 1'b1, status: st_now};
          done_d  = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_SETUP: begin
        ctrl.rd_load = 1'b1;
        state_d      = S_DIV;
      end
      S_DIV: begin
        if (mod_done) begin
          ticket_d = mod_rem;
          walk_d   = count_q - CW'(1);
          state_d  = S_WALK;
        end
      end
      S_WALK: begin
        // advance one entry per cycle until the draw falls in the front range or no entry is left to walk past
        if (ticket_q >= TW'(tpt) && walk_q != '0) begin
          ticket_d      = ticket_q - TW'(tpt);
          walk_d        = walk_q - CW'(1);
          ctrl.rd_shift = 1'b1;
        end else begin
          res_d   = '{next_pid: rd_w[0], next_is_idle: 1'b0, status: st_q};
          done_d  = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      count_q   <= '0;
      tick_q    <= '0;
      scan_q    <= '0;
      walk_q    <= '0;
      st_q      <= ST_OK;
      done_q    <= 1'b0;
      quantum_q <= QUANTUM_RST;
      tickets_q <= TICKETS_RST;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      tick_q  <= tick_d;
      scan_q  <= scan_d;
      walk_q  <= walk_d;
      st_q    <= st_d;
      done_q  <= done_d;
      if (cfg_we_i) begin
        unique case (cfg_reg_e'(cfg_idx_i))
          REG_QUANTUM: quantum_q <= cfg_data_i;
          REG_TICKETS: tickets_q <= cfg_data_i[TKT_W-1:0];
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ticket_q <= ticket_d;
    rnd_q    <= rnd_d;
    res_q    <= res_d;
  end

  assign busy     = (state_q != S_IDLE);
  assign done_o   = done_q;
  assign result_o = res_q;

endmodule

`default_nettype wire

### hw/rtl/lts_checker.sv
`default_nettype none

module lts_checker import lts_pkg::*; (
  input wire logic    clk_i,
  input wire logic    rst_ni,
  input wire logic    start,
  input wire logic    busy,
  input wire logic    done_o,
  input wire result_t result_o
);

  // a transfer in always leads to work or a result in the next cycle
  a_accept_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy || done_o))
    else $error("accepted command produced neither work nor result");

  a_no_spurious_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!start && !busy) |=> !done_o)
    else $error("result without an accepted command");

  a_result_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result shown while still busy");

  a_idle_pid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && result_o.next_is_idle) |-> (result_o.next_pid == '0))
    else $error("idle result carries a pid");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (result_o.status == ST_OK || result_o.status == ST_FULL ||
                result_o.status == ST_NOT_FOUND))
    else $error("undefined status code");

endmodule

bind lottery_task_scheduler_unit lts_checker u_lts_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .start   (start),
  .busy    (busy),
  .done_o  (done_o),
  .result_o(result_o)
);

`default_nettype wire
